### hdl/hfau_pkg.sv
// ----------------------------------------------------------------------------
// hfau_pkg
// Shared types, constants and helper functions of the binary16 arithmetic
// unit: operation codes, rounding modes, controller states and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package hfau_pkg;

   localparam int SIG_W     = 26;   // widest intermediate significand (sum)
   localparam int EXP_W     = 8;    // signed intermediate exponent
   localparam int DIV_STEPS = 14;   // quotient bits of the divider
   localparam int CNT_W     = 4;

   localparam logic [4:0]  EXP_ONES   = 5'd31;
   localparam logic [15:0] MAX_FINITE = 16'h7BFF;
   localparam logic [15:0] INF_BITS   = 16'h7C00;
   localparam logic [15:0] QNAN_BITS  = 16'h7C01;
   localparam logic [15:0] SIGN_BIT   = 16'h8000;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RM_ZERO    = 2'd0,
      RM_NEAREST = 2'd1,
      RM_UP      = 2'd2,
      RM_DOWN    = 2'd3
   } mode_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SETUP = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_NORM  = 5'b01000,
      ST_ROUND = 5'b10000
   } state_type;

   typedef struct packed {
      logic load_in;
      logic setup;
      logic div_step;
      logic norm;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_needed;
   } status_type;

   // Significand of a finite operand, hidden bit included for normals.
   function automatic logic [10:0] unpack_sig(input logic [15:0] x);
      unpack_sig = (x[14:10] != 5'd0) ? {1'b1, x[9:0]} : {1'b0, x[9:0]};
   endfunction

   // Exponent of the significand's lowest bit.
   function automatic logic signed [EXP_W-1:0] unpack_exp(input logic [15:0] x);
      logic [4:0] ef;
      ef = (x[14:10] != 5'd0) ? x[14:10] : 5'd1;
      unpack_exp = $signed({3'b000, ef}) - 8'sd25;
   endfunction

   // Shift that brings the leading one of a nonzero value to bit 10.
   function automatic logic [3:0] lzc11(input logic [10:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 11; i++) begin
         if (v[i]) begin
            n = 4'(10 - i);
         end
      end
      lzc11 = n;
   endfunction

   // Position of the leading one.
   function automatic logic [4:0] lead_pos(input logic [SIG_W-1:0] v);
      logic [4:0] p;
      p = 5'd0;
      for (int i = 0; i < SIG_W; i++) begin
         if (v[i]) begin
            p = 5'(i);
         end
      end
      lead_pos = p;
   endfunction

endpackage

### hdl/half_float_arith_unit.sv
// ----------------------------------------------------------------------------
// half_float_arith_unit
// Binary16 add, subtract, multiply and divide with configurable rounding.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one word per operation: the operands in
//   req_tdata and the operation code in req_tuser. The response channel
//   returns the rounded binary16 result in rsp_tdata, one word per request,
//   in order. The rounding mode is written through csr_wr_en/csr_wr_data
//   while the unit is idle; reset selects round to nearest even.
//   Timing: a request is taken in the idle state, then the setup,
//   normalization and rounding states follow for add, subtract and
//   multiply. Divide adds the restoring divider between setup and
//   normalization, 14 quotient bits at one quotient bit per cycle.
//   The result is valid the cycle after the rounding state loads it.
//   The result register lets the next request enter while a result waits;
//   if the receiver stalls, the unit holds its finished value in the
//   rounding state until the pending word has been taken.
//   Reset is synchronous and empties the unit; no word is presented after it.
// ----------------------------------------------------------------------------
module half_float_arith_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,   // rounding_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // [15:0] operand_a, [31:16] operand_b
   input  logic [1:0]  req_tuser,     // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata      // [15:0] result_value
);

   hfau_pkg::cmd_type    cmd;
   hfau_pkg::status_type status;

   hfau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hfau_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_op      (req_tuser),
      .req_a       (req_tdata[15:0]),
      .req_b       (req_tdata[31:16]),
      .cmd         (cmd),
      .status      (status),
      .result      (rsp_tdata)
   );

endmodule

### hdl/hfau_ctrl.sv
// ----------------------------------------------------------------------------
// hfau_ctrl
// Sequencer of the arithmetic unit: accepts a word, steps the datapath
// through setup, division, normalization and rounding, and owns the result
// valid flag.
// ----------------------------------------------------------------------------
module hfau_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  hfau_pkg::status_type status,
   output hfau_pkg::cmd_type    cmd
);

   hfau_pkg::state_type state_ff, state_in;
   logic [hfau_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == hfau_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         hfau_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = hfau_pkg::ST_SETUP;
            end
         end
         hfau_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in    = '0;
            state_in  = status.div_needed ? hfau_pkg::ST_DIV : hfau_pkg::ST_NORM;
         end
         hfau_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == hfau_pkg::CNT_W'(hfau_pkg::DIV_STEPS - 1)) begin
               state_in = hfau_pkg::ST_NORM;
            end
         end
         hfau_pkg::ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = hfau_pkg::ST_ROUND;
         end
         hfau_pkg::ST_ROUND: begin
            // The result register is only overwritten once the previous
            // word has been taken.
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = hfau_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hfau_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hfau_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/hfau_datapath.sv
// ----------------------------------------------------------------------------
// hfau_datapath
// Operand registers, special-case decode, aligned add, multiplier,
// restoring divider, leading-one detect and the rounding and packing stage.
// ----------------------------------------------------------------------------
module hfau_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_wr_data,
   input  logic [1:0]          req_op,
   input  logic [15:0]         req_a,
   input  logic [15:0]         req_b,
   input  hfau_pkg::cmd_type    cmd,
   output hfau_pkg::status_type status,
   output logic [15:0]         result
);

   localparam int SW = hfau_pkg::SIG_W;
   localparam int EW = hfau_pkg::EXP_W;

   logic [1:0]           mode_ff;
   logic [1:0]           op_ff;
   logic [15:0]          a_ff, b_ff;
   logic                 special_ff, special_in;
   logic [15:0]          spec_val_ff, spec_val_in;
   logic                 neg_ff, neg_in;
   logic [SW-1:0]        sig_ff, sig_in;
   logic signed [EW-1:0] exp_ff, exp_in;
   logic                 sticky_ff;
   logic [11:0]          rem_ff, rem_in;
   logic [10:0]          divisor_ff, divisor_in;
   logic [4:0]           p_ff;
   logic [15:0]          result_ff, result_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= hfau_pkg::RM_NEAREST;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // ---------------- operand decode ----------------
   logic [15:0] b_eff;
   logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sa, sb, sx;
   logic [15:0] nan_gen, inf_x, zero_x, signed_zero_add;

   assign b_eff  = (op_ff == hfau_pkg::OP_SUB) ? (b_ff ^ hfau_pkg::SIGN_BIT) : b_ff;
   assign a_nan  = (a_ff[14:10] == hfau_pkg::EXP_ONES) && (a_ff[9:0] != 10'd0);
   assign b_nan  = (b_ff[14:10] == hfau_pkg::EXP_ONES) && (b_ff[9:0] != 10'd0);
   assign a_inf  = (a_ff[14:10] == hfau_pkg::EXP_ONES) && (a_ff[9:0] == 10'd0);
   assign b_inf  = (b_ff[14:10] == hfau_pkg::EXP_ONES) && (b_ff[9:0] == 10'd0);
   assign a_zero = (a_ff[14:0] == 15'd0);
   assign b_zero = (b_ff[14:0] == 15'd0);
   assign sa     = a_ff[15];
   assign sb     = b_eff[15];
   assign sx     = sa ^ sb;
   assign nan_gen = {sa, 15'd0} | hfau_pkg::QNAN_BITS;
   assign inf_x   = {sx, 15'd0} | hfau_pkg::INF_BITS;
   assign zero_x  = {sx, 15'd0};
   assign signed_zero_add = (mode_ff == hfau_pkg::RM_DOWN) ? hfau_pkg::SIGN_BIT : 16'h0000;

   always_comb begin
      special_in  = 1'b1;
      spec_val_in = 16'h0000;
      if (a_nan) begin
         spec_val_in = a_ff;
      end else if (b_nan) begin
         spec_val_in = b_ff;
      end else begin
         case (op_ff)
            hfau_pkg::OP_ADD, hfau_pkg::OP_SUB: begin
               if (a_inf && b_inf && (sa != sb)) begin
                  spec_val_in = nan_gen;
               end else if (a_inf) begin
                  spec_val_in = a_ff;
               end else if (b_inf) begin
                  spec_val_in = b_eff;
               end else if (a_zero && b_zero) begin
                  spec_val_in = (sa == sb) ? {sa, 15'd0} : signed_zero_add;
               end else if (a_zero) begin
                  spec_val_in = b_eff;
               end else if (b_zero) begin
                  spec_val_in = a_ff;
               end else if ((a_ff[14:0] == b_eff[14:0]) && (sa != sb)) begin
                  spec_val_in = signed_zero_add;
               end else begin
                  special_in = 1'b0;
               end
            end
            hfau_pkg::OP_MUL: begin
               if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                  spec_val_in = nan_gen;
               end else if (a_inf || b_inf) begin
                  spec_val_in = inf_x;
               end else if (a_zero || b_zero) begin
                  spec_val_in = zero_x;
               end else begin
                  special_in = 1'b0;
               end
            end
            default: begin
               if ((a_inf && b_inf) || (a_zero && b_zero)) begin
                  spec_val_in = nan_gen;
               end else if (a_inf || b_zero) begin
                  spec_val_in = inf_x;
               end else if (a_zero || b_inf) begin
                  spec_val_in = zero_x;
               end else begin
                  special_in = 1'b0;
               end
            end
         endcase
      end
   end

   assign status.div_needed = (op_ff == hfau_pkg::OP_DIV) && !special_in;

   // ---------------- add / subtract alignment ----------------
   logic [10:0] ma, mb, mbig, msml;
   logic signed [EW-1:0] ea, eb, ebig, esml, ediff;
   logic a_ge;
   logic [15:0] big;
   logic [49:0] shifted;
   logic [24:0] xbig, yf;
   logic ystk;
   logic [25:0] add_res;

   assign ma   = hfau_pkg::unpack_sig(a_ff);
   assign mb   = hfau_pkg::unpack_sig(b_eff);
   assign ea   = hfau_pkg::unpack_exp(a_ff);
   assign eb   = hfau_pkg::unpack_exp(b_eff);
   assign a_ge = (a_ff[14:0] >= b_eff[14:0]);
   assign big  = a_ge ? a_ff : b_eff;
   assign mbig = a_ge ? ma : mb;
   assign msml = a_ge ? mb : ma;
   assign ebig = a_ge ? ea : eb;
   assign esml = a_ge ? eb : ea;
   assign ediff   = ebig - esml;
   assign shifted = {msml, 39'd0} >> ediff[4:0];
   assign yf      = shifted[49:25];
   assign ystk    = (shifted[24:0] != 25'd0);
   assign xbig    = {mbig, 14'd0};

   // The truncated subtrahend bits are folded in as a floor, so the sticky
   // flag always stands for a positive remainder.
   always_comb begin
      if (sa == sb) begin
         add_res = {1'b0, xbig} + {1'b0, yf};
      end else begin
         add_res = {1'b0, xbig} - {1'b0, yf} - {25'd0, ystk};
      end
   end

   // ---------------- multiply and divide setup ----------------
   logic [21:0] prod;
   logic [3:0]  lz_a, lz_b;
   logic [10:0] man, mbn;
   logic signed [EW-1:0] ediv;

   assign prod = {11'd0, ma} * {11'd0, mb};
   assign lz_a = hfau_pkg::lzc11(ma);
   assign lz_b = hfau_pkg::lzc11(mb);
   assign man  = ma << lz_a;
   assign mbn  = mb << lz_b;
   assign ediv = (ea - $signed({4'd0, lz_a})) - (eb - $signed({4'd0, lz_b})) - 8'sd13;

   // ---------------- divider step ----------------
   logic        q_ge;
   logic [11:0] q_diff;

   assign q_ge   = (rem_ff >= {1'b0, divisor_ff});
   assign q_diff = q_ge ? (rem_ff - {1'b0, divisor_ff}) : rem_ff;

   always_comb begin
      sig_in     = sig_ff;
      exp_in     = exp_ff;
      neg_in     = neg_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (cmd.setup) begin
         rem_in     = 12'd0;
         divisor_in = mbn;
         case (op_ff)
            hfau_pkg::OP_ADD, hfau_pkg::OP_SUB: begin
               sig_in = add_res;
               exp_in = ebig - 8'sd14;
               neg_in = big[15];
            end
            hfau_pkg::OP_MUL: begin
               sig_in = {4'd0, prod};
               exp_in = ea + eb;
               neg_in = sx;
            end
            default: begin
               sig_in = '0;
               exp_in = ediv;
               neg_in = sx;
               rem_in = {1'b0, man};
            end
         endcase
      end else if (cmd.div_step) begin
         sig_in = {sig_ff[SW-2:0], q_ge};
         rem_in = {q_diff[10:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         op_ff <= req_op;
         a_ff  <= req_a;
         b_ff  <= req_b;
      end
      if (cmd.setup) begin
         special_ff  <= special_in;
         spec_val_ff <= spec_val_in;
         sticky_ff   <= (op_ff == hfau_pkg::OP_ADD || op_ff == hfau_pkg::OP_SUB) && ystk;
      end else if (cmd.norm) begin
         sticky_ff <= sticky_ff | (rem_ff != 12'd0);
      end
      if (cmd.norm) begin
         p_ff <= hfau_pkg::lead_pos(sig_ff);
      end
      sig_ff     <= sig_in;
      exp_ff     <= exp_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      if (cmd.load_out) begin
         result_ff <= result_in;
      end
   end

   // ---------------- rounding and packing ----------------
   logic signed [EW-1:0] q_raw, q, shift, q_fin, nshift;
   logic [31:0] sig32, low_mask;
   logic [4:0]  shamt;
   logic [10:0] kept;
   logic [11:0] kept_inc;
   logic [10:0] kept_fin;
   logic guard, low, inexact, inc;
   logic [15:0] sbit, rounded;

   assign sbit  = {neg_ff, 15'd0};
   assign q_raw = exp_ff + $signed({3'd0, p_ff}) - 8'sd10;
   assign q     = (q_raw < -8'sd24) ? -8'sd24 : q_raw;
   assign shift = q - exp_ff;
   assign nshift = -shift;
   assign sig32 = {{(32-SW){1'b0}}, sig_ff};
   assign shamt = shift[4:0];
   assign low_mask = (32'd1 << (shamt - 5'd1)) - 32'd1;

   always_comb begin
      if (shift <= 8'sd0) begin
         kept  = 11'(sig32 << nshift[3:0]);
         guard = 1'b0;
         low   = 1'b0;
      end else begin
         kept  = 11'(sig32 >> shamt);
         guard = sig32[shamt - 5'd1];
         low   = ((sig32 & low_mask) != 32'd0);
      end
      inexact = guard || low || sticky_ff;
      case (mode_ff)
         hfau_pkg::RM_NEAREST: inc = guard && (low || sticky_ff || kept[0]);
         hfau_pkg::RM_UP:      inc = !neg_ff && inexact;
         hfau_pkg::RM_DOWN:    inc = neg_ff && inexact;
         default:              inc = 1'b0;
      endcase
      kept_inc = {1'b0, kept} + {11'd0, inc};
      if (kept_inc[11]) begin
         kept_fin = 11'd1024;
         q_fin    = q + 8'sd1;
      end else begin
         kept_fin = kept_inc[10:0];
         q_fin    = q;
      end
      if (sig_ff == '0) begin
         rounded = sbit;
      end else if (!kept_fin[10]) begin
         rounded = sbit | {6'd0, kept_fin[9:0]};
      end else if (q_fin >= 8'sd6) begin
         if (mode_ff == hfau_pkg::RM_NEAREST || (mode_ff == hfau_pkg::RM_UP && !neg_ff) ||
             (mode_ff == hfau_pkg::RM_DOWN && neg_ff)) begin
            rounded = sbit | hfau_pkg::INF_BITS;
         end else begin
            rounded = sbit | hfau_pkg::MAX_FINITE;
         end
      end else begin
         rounded = {neg_ff, 5'(q_fin + 8'sd25), kept_fin[9:0]};
      end
      result_in = special_ff ? spec_val_ff : rounded;
   end

   assign result = result_ff;

endmodule

### hdl/hfau_checker.sv
// ----------------------------------------------------------------------------
// hfau_checker
// Port-level checks of the arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module hfau_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // Nothing is presented right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // The unit works on one word at a time: it is not ready in the setup state and the state that follows.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("request taken while busy");

   // A fresh result needs setup and rounding cycles after the accept.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared too early");

endmodule

bind half_float_arith_unit hfau_checker u_hfau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
